/* sv/tpsc_pkg.sv */
// Shared types, widths and constants for the throttle / pedal-assist sensor conditioner.
// Used by every module of the block; depends on nothing.
package tpsc_pkg;

  localparam int ADC_BITS  = 12;
  localparam int FRAC_BITS = 16;

  // Q0.FRAC_BITS one and full scale.
  localparam logic [FRAC_BITS:0]   FRAC_ONE  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] FRAC_FULL = '1;

  // Serial unit widths.
  localparam int ACC_W     = FRAC_BITS + 2;
  localparam int DIV_CNT_W = $clog2(FRAC_BITS);
  localparam int MUL_CNT_W = $clog2(FRAC_BITS + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (ADC_BITS > FRAC_BITS + 1) ? ADC_BITS : FRAC_BITS + 1;

  localparam logic [CFG_IDX_W-1:0] REG_ADC_MIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_MAX       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ALPHA  = 3'd4;

  // Register reset values; fractions are rounded to the nearest code.
  localparam logic [ADC_BITS-1:0]  RST_ADC_MIN = ADC_BITS'(200);
  localparam logic [ADC_BITS-1:0]  RST_ADC_MAX = ADC_BITS'(3800);
  localparam longint ONE_L = longint'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] RST_DZ_LOW  = FRAC_BITS'((ONE_L * 5 + 50) / 100);
  localparam logic [FRAC_BITS-1:0] RST_DZ_HIGH = FRAC_BITS'((ONE_L * 2 + 50) / 100);
  localparam logic [FRAC_BITS:0]   RST_ALPHA   = (FRAC_BITS + 1)'((ONE_L * 15 + 50) / 100);

  localparam logic MODE_PULSE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [ADC_BITS-1:0] throttle_raw;
    logic                hall_a;
    logic                hall_b;
    logic                button_in;
  } in_item_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] throttle_level;
    logic                 pas_active;
    logic [1:0]           hall_state;
    logic                 button_pressed;
  } out_item_t;

  typedef struct packed {
    logic                start;
    logic [ADC_BITS-1:0] num;
    logic [ADC_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic [FRAC_BITS:0] alpha;
    logic [FRAC_BITS:0] diff;
  } mul_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DZ,
    ST_MUL,
    ST_OUT
  } tpsc_state_t;

endpackage

/* sv/tpsc_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, FRAC_BITS bits in all.
// Depends on tpsc_pkg. The numerator must be below the denominator.
module tpsc_div
  import tpsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  div_req_t             req,
  output logic                 done,
  output logic [FRAC_BITS-1:0] quo
);

  logic [ADC_BITS-1:0]  rem_r, rem_nxt;
  logic [ADC_BITS-1:0]  den_r, den_nxt;
  logic [FRAC_BITS-1:0] quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [ADC_BITS:0]    sh;
  logic [ADC_BITS:0]    sub;
  logic                 ge;

  always_comb begin
    sh       = {rem_r, 1'b0};
    sub      = sh - {1'b0, den_r};
    ge       = (sh >= {1'b0, den_r});
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.num;
      den_nxt  = req.den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? sub[ADC_BITS-1:0] : sh[ADC_BITS-1:0];
      quo_nxt = {quo_r[FRAC_BITS-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(FRAC_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* sv/tpsc_mul.sv */
// Bit-serial signed multiplier, LSB first over the weight bits, that returns
// floor(alpha * diff / 2^FRAC_BITS). Depends on tpsc_pkg.
module tpsc_mul
  import tpsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  mul_req_t         req,
  output logic             done,
  output logic [ACC_W-1:0] prod
);

  logic [FRAC_BITS:0]   a_r, a_nxt;
  logic [FRAC_BITS:0]   d_r, d_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [ACC_W:0]       pp;
  logic [ACC_W:0]       sum;

  always_comb begin
    // Partial product sign-extended to the sum width.
    pp       = a_r[0] ? {{2{d_r[FRAC_BITS]}}, d_r} : '0;
    sum      = {acc_r[ACC_W-1], acc_r} + pp;
    a_nxt    = a_r;
    d_nxt    = d_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      a_nxt    = req.alpha;
      d_nxt    = req.diff;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      a_nxt   = a_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(FRAC_BITS)) begin
        // The top weight bit carries no shift.
        acc_nxt  = sum[ACC_W-1:0];
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        // Arithmetic shift right drops one fraction bit; floors compose exactly.
        acc_nxt = sum[ACC_W:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    d_r   <= d_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

/* sv/throttle_pas_sensor_conditioner.sv */
// Top level of the throttle / pedal-assist sensor conditioner.
// Depends on tpsc_pkg, tpsc_div and tpsc_mul.
//
// The block takes one item at a time. A pedal pulse transfer (mode 0) only
// marks pedal activity; the block stays idle and gives no result. A sample
// transfer (mode 1) maps the raw reading onto a Q0.16 fraction, applies the
// low and high dead zones and an exponential moving average, and produces
// one result. A reading strictly inside the calibrated span goes through the
// bit-serial divider, one quotient bit a cycle; other readings skip it. The
// moving average always goes through the bit-serial multiplier, one weight
// bit a cycle. A sample steps from idle through the divide state (when it
// is divided), the dead-zone step, the multiply state and the output state.
// The result sits in an output register, so the block returns to idle and
// takes pedal pulses while a result waits; the next sample finishes its
// work and then waits for that register to empty. Configuration writes are
// always ready and update their register at once, so a write while a sample
// is in work can still change that sample's dead zones or smoothing weight.
module throttle_pas_sensor_conditioner
  import tpsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [ADC_BITS-1:0]  adc_min_r;
  logic [ADC_BITS-1:0]  adc_max_r;
  logic [FRAC_BITS-1:0] dz_low_r;
  logic [FRAC_BITS-1:0] dz_high_r;
  logic [FRAC_BITS:0]   alpha_r;

  // Control and datapath registers.
  tpsc_state_t          state_r, state_nxt;
  logic [FRAC_BITS-1:0] m_r, m_nxt;
  logic [FRAC_BITS-1:0] s_r, s_nxt;
  logic                 pulse_r, pulse_nxt;
  logic                 pas_r, pas_nxt;
  logic [1:0]           hall_r, hall_nxt;
  logic                 btn_r, btn_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  div_req_t             div_req;
  logic                 div_done;
  logic [FRAC_BITS-1:0] div_quo;
  mul_req_t             mul_req;
  logic                 mul_done;
  logic [ACC_W-1:0]     mul_prod;

  logic [FRAC_BITS:0]   hi_limit;
  logic [FRAC_BITS-1:0] m_dz;
  logic [FRAC_BITS:0]   alpha_eff;
  logic [ACC_W-1:0]     s_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adc_min_r <= RST_ADC_MIN;
      adc_max_r <= RST_ADC_MAX;
      dz_low_r  <= RST_DZ_LOW;
      dz_high_r <= RST_DZ_HIGH;
      alpha_r   <= RST_ALPHA;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ADC_MIN:       adc_min_r <= cfg_data[ADC_BITS-1:0];
        REG_ADC_MAX:       adc_max_r <= cfg_data[ADC_BITS-1:0];
        REG_DEADZONE_LOW:  dz_low_r  <= cfg_data[FRAC_BITS-1:0];
        REG_DEADZONE_HIGH: dz_high_r <= cfg_data[FRAC_BITS-1:0];
        REG_SMOOTH_ALPHA:  alpha_r   <= cfg_data[FRAC_BITS:0];
        default: ;
      endcase
    end
  end

  // Dead zones on the mapped value. The high zone starts above one minus
  // deadzone_high, computed one bit wider so that a zero width never fires.
  always_comb begin
    hi_limit = FRAC_ONE - {1'b0, dz_high_r};
    if (m_r < dz_low_r) begin
      m_dz = '0;
    end else if ({1'b0, m_r} > hi_limit) begin
      m_dz = FRAC_FULL;
    end else begin
      m_dz = m_r;
    end
    // Weights above one act as one.
    alpha_eff = (alpha_r > FRAC_ONE) ? FRAC_ONE : alpha_r;
    // New level is s + floor(alpha * (m - s) / one); it always lands in range.
    s_sum = {2'b00, s_r} + mul_prod;
  end

  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    s_nxt         = s_r;
    pulse_nxt     = pulse_r;
    pas_nxt       = pas_r;
    hall_nxt      = hall_r;
    btn_nxt       = btn_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_req.start = 1'b0;
    div_req.num   = in_data.throttle_raw - adc_min_r;
    div_req.den   = adc_max_r - adc_min_r;
    mul_req.start = 1'b0;
    mul_req.alpha = alpha_eff;
    mul_req.diff  = {1'b0, m_dz} - {1'b0, s_r};
    in_ready      = (state_r == ST_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.mode == MODE_PULSE) begin
            pulse_nxt = 1'b1;
          end else begin
            pas_nxt   = pulse_r;
            pulse_nxt = 1'b0;
            hall_nxt  = {in_data.hall_a, in_data.hall_b};
            btn_nxt   = in_data.button_in;
            if (in_data.throttle_raw <= adc_min_r) begin
              m_nxt     = '0;
              state_nxt = ST_DZ;
            end else if (in_data.throttle_raw >= adc_max_r) begin
              // Covers an empty or inverted span and a quotient of one or more.
              m_nxt     = FRAC_FULL;
              state_nxt = ST_DZ;
            end else begin
              div_req.start = 1'b1;
              state_nxt     = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          m_nxt     = div_quo;
          state_nxt = ST_DZ;
        end
      end
      ST_DZ: begin
        mul_req.start = 1'b1;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          s_nxt     = s_sum[FRAC_BITS-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.throttle_level = s_r;
          out_data_nxt.pas_active     = pas_r;
          out_data_nxt.hall_state     = hall_r;
          out_data_nxt.button_pressed = btn_r;
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s_r         <= '0;
      pulse_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s_r         <= s_nxt;
      pulse_r     <= pulse_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r        <= m_nxt;
    pas_r      <= pas_nxt;
    hall_r     <= hall_nxt;
    btn_r      <= btn_nxt;
    out_data_r <= out_data_nxt;
  end

  tpsc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  tpsc_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_prod)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/tpsc_checker.sv */
// Port-level checks for the sensor conditioner, bound to the top level.
// Depends on tpsc_pkg.
module tpsc_checker
  import tpsc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A sample transfer starts work, so the input side goes busy.
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.mode == MODE_SAMPLE |=> !in_ready)
    else $error("input still ready after a sample transfer");

  // A pedal pulse transfer leaves the block ready for the next item.
  a_pulse_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.mode == MODE_PULSE |=> in_ready)
    else $error("block went busy after a pulse transfer");

  // A new result appears only at the end of work, when input was not ready.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without preceding work");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

endmodule

bind throttle_pas_sensor_conditioner tpsc_checker u_tpsc_checker (.*);
